/* src/http_date_to_epoch_parser_defines.svh */
// Assertion macros used by the HTTP date parser controller
`ifndef HTTP_DATE_TO_EPOCH_PARSER_DEFINES_SVH
`define HTTP_DATE_TO_EPOCH_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HDTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define HDTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/hdte_pkg.sv */
// Types, constants and helper functions of the HTTP date parser
package hdte_pkg;

   localparam int ACC_W = 14;

   localparam logic [ACC_W-1:0] ACC_MAX = 14'd9999;

   // accumulator select codes
   typedef logic [2:0] acc_sel_type;
   localparam acc_sel_type ACC_NONE = 3'd0;
   localparam acc_sel_type ACC_DAY  = 3'd1;
   localparam acc_sel_type ACC_YEAR = 3'd2;
   localparam acc_sel_type ACC_HOUR = 3'd3;
   localparam acc_sel_type ACC_MIN  = 3'd4;
   localparam acc_sel_type ACC_SEC  = 3'd5;

   // characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   // date limits
   localparam logic [ACC_W-1:0] TWO_DIGIT_LIM = 14'd100;
   localparam logic [ACC_W-1:0] PIVOT_YY      = 14'd70;
   localparam logic [ACC_W-1:0] CENTURY_21    = 14'd2000;
   localparam logic [ACC_W-1:0] CENTURY_20    = 14'd1900;
   localparam logic [ACC_W-1:0] YEAR_MIN      = 14'd1970;
   localparam logic [ACC_W-1:0] YEAR_MAX      = 14'd2100;
   localparam logic [ACC_W-1:0] MDAY_MAX      = 14'd31;
   localparam logic [3:0]       MONTH_MAX     = 4'd12;
   localparam logic [3:0]       MONTH_FEB     = 4'd2;

   // day count relative to a leap-aligned base year
   localparam int BASE_YEAR   = 1968;
   localparam int EPOCH_SHIFT = 719468;
   localparam int DAY_BIAS    = 365 * BASE_YEAR + BASE_YEAR / 4 - BASE_YEAR / 100
                                + BASE_YEAR / 400 - EPOCH_SHIFT;
   localparam logic [7:0] Z_Y2000 = 8'(2000 - BASE_YEAR);
   localparam logic [7:0] Z_Y2100 = 8'(2100 - BASE_YEAR);
   localparam int DAYS_W = 17;

   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;

   typedef struct packed {
      logic is_digit;
      logic is_sep;
      logic is_space;
      logic is_colon;
      logic is_nul;
      logic month_hit;
   } hdte_stat_type;

   typedef struct packed {
      acc_sel_type acc_sel;
      logic        let0_wr;
      logic        let1_wr;
      logic        month_wr;
      logic        calc_a;
      logic        calc_b;
      logic        phase_ok;
      logic        out_load;
   } hdte_cmd_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_SHIFT : c;
   endfunction

   function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] acc,
                                                 input logic [3:0] dig);
      logic [16:0] v;
      v = 17'(acc) * 17'd10 + 17'(dig);
      return (v > 17'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
   endfunction

   function automatic logic [3:0] month_match(input logic [7:0] l0, input logic [7:0] l1,
                                              input logic [7:0] l2);
      logic [3:0] m;
      unique case ({l0, l1, l2})
         "jan":   m = 4'd1;
         "feb":   m = 4'd2;
         "mar":   m = 4'd3;
         "apr":   m = 4'd4;
         "may":   m = 4'd5;
         "jun":   m = 4'd6;
         "jul":   m = 4'd7;
         "aug":   m = 4'd8;
         "sep":   m = 4'd9;
         "oct":   m = 4'd10;
         "nov":   m = 4'd11;
         "dec":   m = 4'd12;
         default: m = 4'd0;
      endcase
      return m;
   endfunction

   // days from 1 March to the first of the month
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] o;
      unique case (m)
         4'd3:    o = 9'd0;
         4'd4:    o = 9'd31;
         4'd5:    o = 9'd61;
         4'd6:    o = 9'd92;
         4'd7:    o = 9'd122;
         4'd8:    o = 9'd153;
         4'd9:    o = 9'd184;
         4'd10:   o = 9'd214;
         4'd11:   o = 9'd245;
         4'd12:   o = 9'd275;
         4'd1:    o = 9'd306;
         4'd2:    o = 9'd337;
         default: o = 9'd0;
      endcase
      return o;
   endfunction

endpackage

/* src/hdte_dpath.sv */
// Datapath: character decode, field accumulators and epoch arithmetic
module hdte_dpath
   import hdte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    req_ch,
   input  hdte_cmd_type  cmd,
   output hdte_stat_type stat,
   output logic [31:0]   rsp_seconds,
   output logic          rsp_understood
);

   logic [ACC_W-1:0] day_acc_ff, day_acc_in;
   logic [ACC_W-1:0] year_acc_ff, year_acc_in;
   logic [ACC_W-1:0] hour_acc_ff, hour_acc_in;
   logic [ACC_W-1:0] minute_acc_ff, minute_acc_in;
   logic [ACC_W-1:0] second_acc_ff, second_acc_in;
   logic [15:0]      month_letters_ff, month_letters_in;
   logic [3:0]       month_num_ff, month_num_in;

   logic              ok_ff;
   logic [DAYS_W-1:0] days_ff;
   logic [31:0]       hsec_ff;
   logic [31:0]       prod_ff;
   logic [31:0]       msec_ff;
   logic [31:0]       rsp_seconds_ff;
   logic              rsp_understood_ff;

   logic [7:0]       ch_low;
   logic [3:0]       digit;
   logic [3:0]       month_hit_num;
   logic [ACC_W-1:0] acc_cur;
   logic [ACC_W-1:0] acc_next;

   logic [ACC_W-1:0]  y_full;
   logic              early;
   logic [7:0]        z;
   logic [1:0]        cent_adj;
   logic              quad_adj;
   logic [8:0]        doy;
   logic [DAYS_W-1:0] days_in;
   logic              ok_in;

   // character decode
   assign ch_low        = to_lower(req_ch);
   assign digit         = 4'(req_ch - CH_ZERO);
   assign month_hit_num = month_match(month_letters_ff[7:0], month_letters_ff[15:8], ch_low);

   assign stat.is_digit  = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign stat.is_sep    = (req_ch == CH_SPACE) || (req_ch == CH_DASH);
   assign stat.is_space  = (req_ch == CH_SPACE);
   assign stat.is_colon  = (req_ch == CH_COLON);
   assign stat.is_nul    = (req_ch == CH_NUL);
   assign stat.month_hit = (month_hit_num != 4'd0);

   always_comb begin
      unique case (cmd.acc_sel)
         ACC_DAY:  acc_cur = day_acc_ff;
         ACC_YEAR: acc_cur = year_acc_ff;
         ACC_HOUR: acc_cur = hour_acc_ff;
         ACC_MIN:  acc_cur = minute_acc_ff;
         ACC_SEC:  acc_cur = second_acc_ff;
         default:  acc_cur = '0;
      endcase
   end

   assign acc_next = acc_add(acc_cur, digit);

   always_comb begin
      day_acc_in       = day_acc_ff;
      year_acc_in      = year_acc_ff;
      hour_acc_in      = hour_acc_ff;
      minute_acc_in    = minute_acc_ff;
      second_acc_in    = second_acc_ff;
      month_letters_in = month_letters_ff;
      month_num_in     = month_num_ff;
      unique case (cmd.acc_sel)
         ACC_DAY:  day_acc_in    = acc_next;
         ACC_YEAR: year_acc_in   = acc_next;
         ACC_HOUR: hour_acc_in   = acc_next;
         ACC_MIN:  minute_acc_in = acc_next;
         ACC_SEC:  second_acc_in = acc_next;
         default:  ;
      endcase
      if (cmd.let0_wr) begin
         month_letters_in = {8'h00, ch_low};
      end
      if (cmd.let1_wr) begin
         month_letters_in = {ch_low, month_letters_ff[7:0]};
      end
      if (cmd.month_wr) begin
         month_num_in = month_hit_num;
      end
      if (cmd.out_load) begin
         day_acc_in       = '0;
         year_acc_in      = '0;
         hour_acc_in      = '0;
         minute_acc_in    = '0;
         second_acc_in    = '0;
         month_letters_in = '0;
         month_num_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_acc_ff       <= '0;
         year_acc_ff      <= '0;
         hour_acc_ff      <= '0;
         minute_acc_ff    <= '0;
         second_acc_ff    <= '0;
         month_letters_ff <= '0;
         month_num_ff     <= '0;
      end else begin
         day_acc_ff       <= day_acc_in;
         year_acc_ff      <= year_acc_in;
         hour_acc_ff      <= hour_acc_in;
         minute_acc_ff    <= minute_acc_in;
         second_acc_ff    <= second_acc_in;
         month_letters_ff <= month_letters_in;
         month_num_ff     <= month_num_in;
      end
   end

   // step A: checks, day count and hour product
   always_comb begin
      if (year_acc_ff < TWO_DIGIT_LIM) begin
         y_full = year_acc_ff + ((year_acc_ff < PIVOT_YY) ? CENTURY_21 : CENTURY_20);
      end else begin
         y_full = year_acc_ff;
      end
   end

   assign early    = (month_num_ff <= MONTH_FEB);
   assign z        = 8'(y_full - 14'(BASE_YEAR) - {13'd0, early});
   assign cent_adj = (z >= Z_Y2100) ? 2'd2 : ((z >= Z_Y2000) ? 2'd1 : 2'd0);
   assign quad_adj = (z >= Z_Y2000);
   assign doy      = month_offset(month_num_ff) + 9'(day_acc_ff) - 9'd1;
   assign days_in  = DAYS_W'(DAYS_W'(z) * DAYS_W'(365)) + DAYS_W'(z >> 2)
                   + DAYS_W'(quad_adj) - DAYS_W'(cent_adj) + DAYS_W'(doy)
                   + DAYS_W'(DAY_BIAS);

   assign ok_in = cmd.phase_ok
                && (day_acc_ff != '0) && (day_acc_ff <= MDAY_MAX)
                && (y_full >= YEAR_MIN) && (y_full <= YEAR_MAX)
                && (month_num_ff != 4'd0) && (month_num_ff <= MONTH_MAX);

   always_ff @(posedge clock) begin
      if (cmd.calc_a) begin
         ok_ff   <= ok_in;
         days_ff <= days_in;
         hsec_ff <= 32'(32'(hour_acc_ff) * SECS_PER_HOUR);
      end
      if (cmd.calc_b) begin
         prod_ff <= 32'(32'(days_ff) * SECS_PER_DAY);
         msec_ff <= hsec_ff + 32'(32'(minute_acc_ff) * SECS_PER_MIN) + 32'(second_acc_ff);
      end
      if (cmd.out_load) begin
         rsp_seconds_ff    <= ok_ff ? (prod_ff + msec_ff) : 32'd0;
         rsp_understood_ff <= ok_ff;
      end
   end

   assign rsp_seconds    = rsp_seconds_ff;
   assign rsp_understood = rsp_understood_ff;

endmodule

/* src/hdte_ctrl.sv */
// Controller: parse phase sequencing, result handshake and arithmetic steps
`include "http_date_to_epoch_parser_defines.svh"

module hdte_ctrl
   import hdte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  hdte_stat_type stat,
   output hdte_cmd_type  cmd
);

   localparam logic [3:0] PH_SEEK  = 4'd0;
   localparam logic [3:0] PH_DAY   = 4'd1;
   localparam logic [3:0] PH_SEP1  = 4'd2;
   localparam logic [3:0] PH_MON1  = 4'd3;
   localparam logic [3:0] PH_MON2  = 4'd4;
   localparam logic [3:0] PH_MWORD = 4'd5;
   localparam logic [3:0] PH_SEP2  = 4'd6;
   localparam logic [3:0] PH_YEAR  = 4'd7;
   localparam logic [3:0] PH_SP3   = 4'd8;
   localparam logic [3:0] PH_HOUR  = 4'd9;
   localparam logic [3:0] PH_MIN   = 4'd10;
   localparam logic [3:0] PH_SEC   = 4'd11;
   localparam logic [3:0] PH_DONE  = 4'd12;
   localparam logic [3:0] PH_FAIL  = 4'd13;

   localparam logic [1:0] ST_PARSE  = 2'd0;
   localparam logic [1:0] ST_CALC_A = 2'd1;
   localparam logic [1:0] ST_CALC_B = 2'd2;
   localparam logic [1:0] ST_CALC_C = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [3:0] phase_ff, phase_in;
   logic       text_ended_ff, text_ended_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic take;
   logic char_go;

   assign req_ready = (state_ff == ST_PARSE);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;
   assign char_go   = take && !text_ended_ff && !stat.is_nul;

   always_comb begin
      cmd           = '0;
      cmd.acc_sel   = ACC_NONE;
      phase_in      = phase_ff;
      text_ended_in = text_ended_ff;
      state_in      = state_ff;

      if (take && !text_ended_ff && stat.is_nul) begin
         text_ended_in = 1'b1;
      end

      if (char_go) begin
         unique case (phase_ff)
            PH_SEEK: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_DAY;
                  phase_in    = PH_DAY;
               end
            end
            PH_DAY: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_DAY;
               end else if (stat.is_sep) begin
                  phase_in = PH_SEP1;
               end else begin
                  cmd.let0_wr = 1'b1;
                  phase_in    = PH_MON1;
               end
            end
            PH_SEP1: begin
               if (!stat.is_sep) begin
                  cmd.let0_wr = 1'b1;
                  phase_in    = PH_MON1;
               end
            end
            PH_MON1: begin
               cmd.let1_wr = 1'b1;
               phase_in    = PH_MON2;
            end
            PH_MON2: begin
               cmd.month_wr = 1'b1;
               phase_in     = stat.month_hit ? PH_MWORD : PH_FAIL;
            end
            PH_MWORD: begin
               if (stat.is_sep) begin
                  phase_in = PH_SEP2;
               end
            end
            PH_SEP2: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_YEAR;
                  phase_in    = PH_YEAR;
               end else if (!stat.is_sep) begin
                  phase_in = PH_DONE;
               end
            end
            PH_YEAR: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_YEAR;
               end else begin
                  phase_in = stat.is_space ? PH_SP3 : PH_DONE;
               end
            end
            PH_SP3: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_HOUR;
                  phase_in    = PH_HOUR;
               end else if (!stat.is_space) begin
                  phase_in = PH_DONE;
               end
            end
            PH_HOUR: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_HOUR;
               end else begin
                  phase_in = stat.is_colon ? PH_MIN : PH_DONE;
               end
            end
            PH_MIN: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_MIN;
               end else begin
                  phase_in = stat.is_colon ? PH_SEC : PH_DONE;
               end
            end
            PH_SEC: begin
               if (stat.is_digit) begin
                  cmd.acc_sel = ACC_SEC;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE, PH_FAIL: ;
            default: phase_in = PH_FAIL;
         endcase
      end

      unique case (state_ff)
         ST_PARSE: begin
            if (take && req_last) begin
               state_in = ST_CALC_A;
            end
         end
         ST_CALC_A: begin
            cmd.calc_a   = 1'b1;
            cmd.phase_ok = (phase_ff >= PH_MWORD) && (phase_ff <= PH_DONE);
            state_in     = ST_CALC_B;
         end
         ST_CALC_B: begin
            cmd.calc_b = 1'b1;
            state_in   = ST_CALC_C;
         end
         ST_CALC_C: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load  = 1'b1;
               phase_in      = PH_SEEK;
               text_ended_in = 1'b0;
               state_in      = ST_PARSE;
            end
         end
         default: state_in = ST_PARSE;
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_PARSE;
         phase_ff      <= PH_SEEK;
         text_ended_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         text_ended_ff <= text_ended_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `HDTE_ASSERT_NEXT(a_last_starts_calc, take && req_last, state_ff == ST_CALC_A, "last beat did not start arithmetic")
   `HDTE_ASSERT_NEXT(a_calc_a_then_b, state_ff == ST_CALC_A, state_ff == ST_CALC_B, "arithmetic step skipped")
   `HDTE_ASSERT_NEXT(a_pending_held, (state_ff == ST_CALC_C) && rsp_valid_ff && !rsp_ready, (state_ff == ST_CALC_C) && rsp_valid_ff, "pending result dropped")
   `HDTE_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid_ff || rsp_ready, "result overwritten before taken")
   `HDTE_ASSERT_NEXT(a_load_restarts, cmd.out_load, rsp_valid_ff && (phase_ff == PH_SEEK) && !text_ended_ff, "parser not restarted after result")

endmodule

/* src/http_date_to_epoch_parser.sv */
// Top level of the HTTP date to Unix seconds parser
//
//   channel   ports                         beat
//   -------   ---------------------------   ----------------------------------
//   request   req_valid/req_ready           req_ch, req_last (one character)
//   response  rsp_valid/rsp_ready           rsp_seconds, rsp_understood
//
// One character is taken per cycle while req_ready is high. After the beat with
// req_last the block runs its date arithmetic (day count, products, sum) and holds
// req_ready low; the sum is registered into the output in the final step.
// A result still waiting in the output register holds the final step, and req_ready
// with it, until rsp_ready takes it. Reset is synchronous and clears the parser.
module http_date_to_epoch_parser
   import hdte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_seconds,
   output logic        rsp_understood
);

   hdte_stat_type stat;
   hdte_cmd_type  cmd;

   hdte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hdte_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_seconds    (rsp_seconds),
      .rsp_understood (rsp_understood)
   );

endmodule
